// ===== sv/ascii_command_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ascii command frame parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH

// implication checked in the same cycle, quiet during reset
`define ACFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, quiet during reset
`define ACFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the next cycle, active through reset
`define ACFP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// types and constants shared by the ascii command frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package acfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned MANT_W    = 54;
    localparam int unsigned FRAC_W    = 5;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] MAX_CHARS  = 5'd16;
    localparam logic [CNT_W-1:0] DIGIT_KEEP = 5'd16;

    localparam logic [BYTE_W-1:0] START_RESET = 8'd36;
    localparam logic [BYTE_W-1:0] STOP_RESET  = 8'd10;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP  = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ID    = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                sign_seen;
        logic                dot_seen;
        logic [CNT_W-1:0]    char_count;
        logic [BYTE_W-1:0]   held_command;
        logic                held_negative;
        logic [MANT_W-1:0]   held_mantissa;
        logic [FRAC_W-1:0]   held_frac_digits;
    } t_frame;

    typedef struct packed {
        logic [BYTE_W-1:0]   command_id;
        logic                negative;
        logic [MANT_W-1:0]   mantissa;
        logic [FRAC_W-1:0]   frac_digits;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/acfp_step.sv =====
// ----------------------------------------------------------------------------
// acfp_step
// next frame state and result for one received byte
// ----------------------------------------------------------------------------
`default_nettype none

module acfp_step (
    input  var acfp_pkg::t_frame                   i_frame,
    input  var logic [acfp_pkg::BYTE_W-1:0]        i_byte,
    input  var logic [acfp_pkg::BYTE_W-1:0]        i_start_char,
    input  var logic [acfp_pkg::BYTE_W-1:0]        i_stop_char,
    output acfp_pkg::t_frame                       o_frame,
    output logic                                   o_emit,
    output acfp_pkg::t_result                      o_result
);
    import acfp_pkg::*;

    logic [CNT_W-1:0]  digits;
    logic [3:0]        digit_val;
    logic [MANT_W-1:0] mant_x10;

    assign digits    = i_frame.char_count - CNT_W'(i_frame.sign_seen)
                       - CNT_W'(i_frame.dot_seen);
    assign digit_val = 4'(i_byte - CH_ZERO);
    // times ten as two shifts and an add
    assign mant_x10  = (i_frame.held_mantissa << 3) + (i_frame.held_mantissa << 1);

    always_comb begin
        o_frame  = i_frame;
        o_emit   = 1'b0;
        o_result = '0;
        case (i_frame.phase)
            PH_IDLE: begin
                o_frame.sign_seen        = 1'b0;
                o_frame.dot_seen         = 1'b0;
                o_frame.char_count       = '0;
                o_frame.held_negative    = 1'b0;
                o_frame.held_mantissa    = '0;
                o_frame.held_frac_digits = '0;
                if (i_byte == i_start_char) begin
                    o_frame.phase = PH_ID;
                end
            end
            PH_ID: begin
                o_frame.sign_seen        = 1'b0;
                o_frame.dot_seen         = 1'b0;
                o_frame.char_count       = '0;
                o_frame.held_negative    = 1'b0;
                o_frame.held_mantissa    = '0;
                o_frame.held_frac_digits = '0;
                if (i_byte != i_start_char) begin
                    o_frame.held_command = i_byte;
                    o_frame.phase        = PH_VALUE;
                end
            end
            PH_VALUE: begin
                // priority: sign, dot, digit, start, stop
                if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                    if (!i_frame.sign_seen && i_frame.char_count == '0) begin
                        o_frame.sign_seen     = 1'b1;
                        o_frame.held_negative = (i_byte == CH_MINUS);
                        o_frame.char_count    = i_frame.char_count + CNT_W'(1);
                    end else begin
                        o_frame.phase = PH_IDLE;
                    end
                end else if (i_byte == CH_DOT) begin
                    if (!i_frame.dot_seen && i_frame.char_count < MAX_CHARS) begin
                        o_frame.dot_seen   = 1'b1;
                        o_frame.char_count = i_frame.char_count + CNT_W'(1);
                    end else begin
                        o_frame.phase = PH_IDLE;
                    end
                end else if (i_byte inside {[CH_ZERO:CH_NINE]}) begin
                    if (i_frame.char_count >= MAX_CHARS) begin
                        o_frame.phase = PH_IDLE;
                    end else begin
                        // digits past the keep limit only count as characters
                        if (digits < DIGIT_KEEP) begin
                            o_frame.held_mantissa = mant_x10 + MANT_W'(digit_val);
                            if (i_frame.dot_seen) begin
                                o_frame.held_frac_digits =
                                    i_frame.held_frac_digits + FRAC_W'(1);
                            end
                        end
                        o_frame.char_count = i_frame.char_count + CNT_W'(1);
                    end
                end else if (i_byte == i_start_char) begin
                    o_frame.phase = PH_ID;
                end else if (i_byte == i_stop_char) begin
                    o_emit               = 1'b1;
                    o_result.command_id  = i_frame.held_command;
                    o_result.negative    = i_frame.held_negative;
                    o_result.mantissa    = i_frame.held_mantissa;
                    o_result.frac_digits = i_frame.held_frac_digits;
                    o_frame.phase        = PH_IDLE;
                end else begin
                    o_frame.phase = PH_IDLE;
                end
            end
            default: begin
                o_frame.phase = PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ascii_command_frame_parser.sv =====
// A result shows on o_valid in the cycle after the stop byte is taken.
// Throughput: one byte per cycle; the frame state steps once per transfer in a
// single registered update, and the output register takes the next byte in the
// same cycle its result is taken; a stalled result holds off the input.
// Reset (synchronous, active low): parser idle, start '$', stop LF, output empty.
// ----------------------------------------------------------------------------
// ascii_command_frame_parser
// frames start char, identifier, signed decimal value and stop char into one
// result holding identifier, sign, mantissa and fraction digit count
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_command_frame_parser (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_cfg_we,
    input  var logic [acfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  var logic [acfp_pkg::BYTE_W-1:0]         i_cfg_wdata,
    input  var logic                                i_valid,
    output logic                                    o_ready,
    input  var logic [acfp_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                    o_valid,
    input  var logic                                i_ready,
    output logic [acfp_pkg::BYTE_W-1:0]             o_command_id,
    output logic                                    o_negative,
    output logic [acfp_pkg::MANT_W-1:0]             o_mantissa,
    output logic [acfp_pkg::FRAC_W-1:0]             o_frac_digits
);
    import acfp_pkg::*;

    logic [BYTE_W-1:0] r_start_char;
    logic [BYTE_W-1:0] r_stop_char;
    t_frame            r_frame;
    t_frame            n_frame;
    logic              n_emit;
    t_result           n_result;
    t_result           r_result;
    logic              r_out_valid;
    logic              in_xfer;

    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    acfp_step u_step (
        .i_frame      (r_frame),
        .i_byte       (i_rx_byte),
        .i_start_char (r_start_char),
        .i_stop_char  (r_stop_char),
        .o_frame      (n_frame),
        .o_emit       (n_emit),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_RESET;
            r_stop_char  <= STOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START: r_start_char <= i_cfg_wdata;
                REG_STOP:  r_stop_char  <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame       <= '0;
            r_frame.phase <= PH_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_frame <= n_frame;
            end
            if (in_xfer && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_command_id  = r_result.command_id;
    assign o_negative    = r_result.negative;
    assign o_mantissa    = r_result.mantissa;
    assign o_frac_digits = r_result.frac_digits;

endmodule

`default_nettype wire

// ===== sv/acfp_checker.sv =====
// ----------------------------------------------------------------------------
// acfp_checker
// port level checks on the parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_command_frame_parser_assert.svh"

module acfp_checker (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_valid,
    input  var logic                                o_ready,
    input  var logic                                o_valid,
    input  var logic                                i_ready,
    input  var logic [acfp_pkg::BYTE_W-1:0]         o_command_id,
    input  var logic                                o_negative,
    input  var logic [acfp_pkg::MANT_W-1:0]         o_mantissa,
    input  var logic [acfp_pkg::FRAC_W-1:0]         o_frac_digits
);
    import acfp_pkg::*;

    // a result needs a byte transfer in the cycle before
    `ACFP_ASSERT_NOW(a_result_from_xfer, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready), "result without input transfer")
    `ACFP_ASSERT_NOW(a_frac_range, i_clk, i_rst_n, o_valid, o_frac_digits <= FRAC_W'(DIGIT_KEEP), "fraction digit count above keep limit")
    `ACFP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid, "output valid after reset")
    `ACFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `ACFP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_command_id) && $stable(o_negative) && $stable(o_mantissa) && $stable(o_frac_digits), "result changed while stalled")

endmodule

bind ascii_command_frame_parser acfp_checker u_acfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_command_id  (o_command_id),
    .o_negative    (o_negative),
    .o_mantissa    (o_mantissa),
    .o_frac_digits (o_frac_digits)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: ascii command frame parser testbench
// streams directed and random byte sequences through the parser, keeps a
// cycle-level predictor of the frame state and compares every reported
// command against it field by field
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned PRINT_CAP   = 200;

    // the two spare codes of the register index
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIGN,
        FLAW_DOT,
        FLAW_FOREIGN,
        FLAW_RESTART,
        FLAW_LONG,
        FLAW_OPEN
    } t_flaw;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [BYTE_W-1:0]    o_command_id;
    logic                 o_negative;
    logic [MANT_W-1:0]    o_mantissa;
    logic [FRAC_W-1:0]    o_frac_digits;

    ascii_command_frame_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_command_id  (o_command_id),
        .o_negative    (o_negative),
        .o_mantissa    (o_mantissa),
        .o_frac_digits (o_frac_digits)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // frame tracker state and its copy of the delimiter registers
    t_frame            frame_st;
    logic [BYTE_W-1:0] cfg_start;
    logic [BYTE_W-1:0] cfg_stop;

    logic [BYTE_W-1:0] rx_queue[$];
    t_result           expected_cmds[$];

    bit          idle_en    = 1'b1;
    bit          byte_taken = 1'b0;
    int unsigned send_gap   = 0;
    int unsigned take_gap   = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_in   = 0;
    int unsigned cmds_seen  = 0;
    int unsigned frames_sent = 0;
    int unsigned settings_run = 0;

    // steps the frame tracker by one byte; returns 1 when a command completes
    function automatic bit frame_step(input logic [BYTE_W-1:0] b,
                                      output t_result cmd);
        logic [CNT_W-1:0] kept;
        cmd = '0;
        case (frame_st.phase)
            PH_IDLE, PH_ID: begin
                frame_st.sign_seen        = 1'b0;
                frame_st.dot_seen         = 1'b0;
                frame_st.char_count       = '0;
                frame_st.held_negative    = 1'b0;
                frame_st.held_mantissa    = '0;
                frame_st.held_frac_digits = '0;
                if (b == cfg_start) begin
                    frame_st.phase = PH_ID;
                end else if (frame_st.phase == PH_ID) begin
                    frame_st.held_command = b;
                    frame_st.phase        = PH_VALUE;
                end
                return 1'b0;
            end
            PH_VALUE: ;
            default: begin
                frame_st.phase = PH_IDLE;
                return 1'b0;
            end
        endcase

        // sign, dot, digit, start, stop: first match wins
        if (b == CH_PLUS || b == CH_MINUS) begin
            if (!frame_st.sign_seen && frame_st.char_count == 0) begin
                frame_st.sign_seen     = 1'b1;
                frame_st.held_negative = (b == CH_MINUS);
                frame_st.char_count    = frame_st.char_count + 1'b1;
            end else begin
                frame_st.phase = PH_IDLE;
            end
        end else if (b == CH_DOT) begin
            if (!frame_st.dot_seen && frame_st.char_count < MAX_CHARS) begin
                frame_st.dot_seen   = 1'b1;
                frame_st.char_count = frame_st.char_count + 1'b1;
            end else begin
                frame_st.phase = PH_IDLE;
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (frame_st.char_count >= MAX_CHARS) begin
                frame_st.phase = PH_IDLE;
            end else begin
                kept = frame_st.char_count - CNT_W'(frame_st.sign_seen)
                       - CNT_W'(frame_st.dot_seen);
                if (kept < DIGIT_KEEP) begin
                    frame_st.held_mantissa = frame_st.held_mantissa * MANT_W'(10)
                                             + MANT_W'(b - CH_ZERO);
                    if (frame_st.dot_seen)
                        frame_st.held_frac_digits = frame_st.held_frac_digits + 1'b1;
                end
                frame_st.char_count = frame_st.char_count + 1'b1;
            end
        end else if (b == cfg_start) begin
            frame_st.phase = PH_ID;
        end else if (b == cfg_stop) begin
            cmd.command_id  = frame_st.held_command;
            cmd.negative    = frame_st.held_negative;
            cmd.mantissa    = frame_st.held_mantissa;
            cmd.frac_digits = frame_st.held_frac_digits;
            frame_st.phase  = PH_IDLE;
            return 1'b1;
        end else begin
            frame_st.phase = PH_IDLE;
        end
        return 1'b0;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, seen);
        end
    endfunction

    // byte source and command sink, both changing on the falling edge
    always @(negedge i_clk) begin : drive_proc
        logic              nxt_valid;
        logic              nxt_ready;
        logic [BYTE_W-1:0] nxt_byte;
        nxt_valid = i_valid;
        nxt_byte  = i_rx_byte;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (byte_taken || !i_valid) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (rx_queue.size() != 0) begin
                    if (idle_en && $urandom_range(0, 11) == 0) begin
                        send_gap = $urandom_range(1, 17) - 1;
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_byte  = rx_queue.pop_front();
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                take_gap = $urandom_range(1, 17) - 1;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_valid   <= nxt_valid;
        i_rx_byte <= nxt_byte;
        i_ready   <= nxt_ready;
    end

    // results are checked before the byte of this edge is predicted
    always @(posedge i_clk) begin : watch_proc
        t_result want;
        t_result fresh;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                cmds_seen++;
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP)
                        $display("%0t: command with none expected, %s %0d",
                                 $time, "expected nothing, actual id", o_command_id);
                end else begin
                    want = expected_cmds.pop_front();
                    compare_field("command_id", 64'(want.command_id), 64'(o_command_id));
                    compare_field("negative", 64'(want.negative), 64'(o_negative));
                    compare_field("mantissa", 64'(want.mantissa), 64'(o_mantissa));
                    compare_field("frac_digits", 64'(want.frac_digits),
                                  64'(o_frac_digits));
                end
            end
            if (i_valid && o_ready) begin
                bytes_in++;
                if (frame_step(i_rx_byte, fresh))
                    expected_cmds.push_back(fresh);
            end
            byte_taken <= i_valid && o_ready;
        end else begin
            byte_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sampled on the rising edge, where the driver never touches the queue
    task automatic wait_quiet();
        while (rx_queue.size() != 0 || i_valid || expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_START: cfg_start = val;
            REG_STOP:  cfg_stop  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // a byte with no special role, so that frames can complete
    function automatic logic [BYTE_W-1:0] plain_byte(input logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == avoid || b == CH_PLUS || b == CH_MINUS || b == CH_DOT ||
               (b >= CH_ZERO && b <= CH_NINE));
        return b;
    endfunction

    task automatic push_frame();
        int unsigned       n_chars;
        int unsigned       dot_at;
        int unsigned       flaw_at;
        int unsigned       i;
        t_flaw             flaw;
        bit                nines;
        bit                with_sign;
        logic [BYTE_W-1:0] id_byte;
        n_chars = ($urandom_range(0, 7) == 0) ? MAX_CHARS : $urandom_range(0, 10);
        flaw    = ($urandom_range(0, 4) == 0) ? t_flaw'($urandom_range(FLAW_SIGN, FLAW_OPEN))
                                              : FLAW_NONE;
        if (flaw == FLAW_LONG)
            n_chars = MAX_CHARS + $urandom_range(1, 2);
        nines     = (n_chars == MAX_CHARS) && $urandom_range(0, 1);
        with_sign = !nines && n_chars != 0 && $urandom_range(0, 2) != 0;
        dot_at    = (!nines && $urandom_range(0, 1)) ? $urandom_range(0, n_chars) : n_chars;
        flaw_at   = $urandom_range(0, n_chars);
        id_byte   = BYTE_W'($urandom_range(0, 255));
        if (id_byte == cfg_start)
            id_byte = ~id_byte;
        rx_queue.push_back(cfg_start);
        rx_queue.push_back(id_byte);
        for (i = 0; i <= n_chars; i++) begin
            if (i == flaw_at) begin
                case (flaw)
                    FLAW_SIGN:
                        rx_queue.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                    FLAW_DOT: begin
                        rx_queue.push_back(CH_DOT);
                        rx_queue.push_back(CH_DOT);
                    end
                    FLAW_FOREIGN: rx_queue.push_back(BYTE_W'($urandom_range(0, 255)));
                    FLAW_RESTART: rx_queue.push_back(cfg_start);
                    default: ;
                endcase
            end
            if (i < n_chars) begin
                if (i == 0 && with_sign)
                    rx_queue.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                else if (i == dot_at)
                    rx_queue.push_back(CH_DOT);
                else
                    rx_queue.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        if (flaw != FLAW_OPEN)
            rx_queue.push_back(cfg_stop);
        frames_sent++;
    endtask

    task automatic run_setting(input logic [BYTE_W-1:0] start_b,
                               input logic [BYTE_W-1:0] stop_b,
                               input bit with_idle, input int unsigned n_bytes);
        wait_quiet();
        idle_en = with_idle;
        write_reg(REG_START, start_b);
        write_reg(REG_STOP, stop_b);
        settings_run++;
        @(posedge i_clk);
        while (rx_queue.size() < n_bytes) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) rx_queue.push_back(BYTE_W'($urandom_range(0, 255)));
            else
                push_frame();
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] rnd_start;
        frame_st  = '0;
        frame_st.phase = PH_IDLE;
        cfg_start = START_RESET;
        cfg_stop  = STOP_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // signed fraction, start repeated as identifier slot, stop byte as
        // identifier with only a sign and a dot as value, restart inside the value
        rx_queue = '{cfg_start, 8'h41, CH_MINUS, CH_ZERO + 8'd1, CH_DOT, CH_ZERO + 8'd5,
                     cfg_stop,
                     cfg_start, cfg_start, 8'h00, cfg_stop,
                     cfg_start, cfg_stop, CH_PLUS, CH_DOT, cfg_stop,
                     cfg_start, 8'hFF, CH_NINE, CH_ZERO, cfg_start, 8'h5A, CH_ZERO + 8'd5,
                     cfg_stop};
        frames_sent += 4;
        settings_run++;

        run_setting(START_RESET, STOP_RESET, 1'b1, 250);
        run_setting(8'h00, 8'hFF, 1'b1, 200);
        run_setting(8'hFF, 8'h00, 1'b0, 200);

        // spare indexes must leave the delimiters alone
        wait_quiet();
        write_reg(REG_SPARE_LO, BYTE_W'($urandom_range(0, 255)));
        write_reg(REG_SPARE_HI, BYTE_W'($urandom_range(0, 255)));
        run_setting(CH_ZERO + 8'd7, CH_PLUS, 1'b1, 100);

        rnd_start = plain_byte(8'h00);
        run_setting(rnd_start, plain_byte(rnd_start), 1'b1, 250);
        rnd_start = plain_byte(8'hFF);
        run_setting(rnd_start, plain_byte(rnd_start), 1'b1, 200);
        run_setting(START_RESET, STOP_RESET, 1'b0, 300);

        wait_quiet();
        $display("summary: %0d bytes in %0d frames over %0d delimiter settings",
                 bytes_in, frames_sent, settings_run);
        $display("summary: %0d commands checked with extreme and overlapping %s, %0d mismatches",
                 cmds_seen, "delimiters", mismatches);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/acfp_pkg.sv
sv/acfp_step.sv
sv/ascii_command_frame_parser.sv
sv/acfp_checker.sv
tb/sv/tb_top.sv
